// ===== src/eit_event_loop_parser_assert.svh =====
// Assertion macros shared by the event loop parser modules
`ifndef EIT_EVENT_LOOP_PARSER_ASSERT_SVH
`define EIT_EVENT_LOOP_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define EEP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define EEP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/eep_pkg.sv =====
// Types and constants of the event information section parser
package eep_pkg;

    localparam int MaxSectionBytes = 4096;
    localparam int C_POS_W         = $clog2(MaxSectionBytes);
    localparam int C_TOTAL_W       = C_POS_W + 1;
    localparam int C_DLL_W         = 12;
    localparam int C_EVENT_BYTES   = 12;
    localparam int C_IDX_W         = $clog2(C_EVENT_BYTES);
    localparam int C_CRC_BYTES     = 4;
    localparam int C_LEN_OFFSET    = 3;
    localparam int C_QUEUE_DEPTH   = 4;
    localparam int C_QPTR_W        = $clog2(C_QUEUE_DEPTH);
    localparam int C_BCD_MAX       = 999999;

    // Byte positions within the section header
    localparam logic [C_POS_W-1:0] P_LEN_HI     = C_POS_W'(1);
    localparam logic [C_POS_W-1:0] P_LEN_LO     = C_POS_W'(2);
    localparam logic [C_POS_W-1:0] P_SID_HI     = C_POS_W'(3);
    localparam logic [C_POS_W-1:0] P_SID_LO     = C_POS_W'(4);
    localparam logic [C_POS_W-1:0] P_TSID_HI    = C_POS_W'(8);
    localparam logic [C_POS_W-1:0] P_TSID_LO    = C_POS_W'(9);
    localparam logic [C_POS_W-1:0] P_ONID_HI    = C_POS_W'(10);
    localparam logic [C_POS_W-1:0] P_ONID_LO    = C_POS_W'(11);
    localparam logic [C_POS_W-1:0] P_SEG_LAST   = C_POS_W'(12);
    localparam logic [C_POS_W-1:0] P_LAST_TABLE = C_POS_W'(13);
    localparam logic [C_POS_W-1:0] P_LOOP_START = C_POS_W'(14);

    // Raw event record passed from the front end to the back end
    typedef struct packed {
        logic [15:0]        event_id;
        logic [15:0]        start_mjd;
        logic [23:0]        start_bcd;
        logic [23:0]        duration_bcd;
        logic [2:0]         running_status;
        logic               free_ca_mode;
        logic [C_DLL_W-1:0] descriptor_loop_length;
        logic [15:0]        service_id;
        logic [15:0]        transport_stream_id;
        logic [15:0]        original_network_id;
        logic [7:0]         segment_last_section;
        logic [7:0]         last_table_number;
    } t_evt_rec;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_queue_status;

endpackage

// ===== src/eep_front.sv =====
// Byte-level section walker: header latching, event collection, descriptor skip
`include "eit_event_loop_parser_assert.svh"

module eep_front import eep_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [7:0]    i_section_byte,
    input  logic          i_first_byte,
    input  t_queue_status i_q_status,
    output logic          o_push,
    output t_evt_rec      o_rec
);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_EVENT  = 4'b0100,
        PH_SKIP   = 4'b1000
    } t_phase;

    t_phase               r_phase, n_phase, w_phase;
    logic [C_POS_W-1:0]   r_pos, n_pos, w_pos;
    logic [C_TOTAL_W-1:0] r_total, n_total, w_total, w_pos1;
    logic [C_DLL_W-1:0]   r_skip, n_skip, w_skip, w_dll;
    logic [C_IDX_W-1:0]   r_idx, n_idx, w_idx;
    logic [15:0]          r_service_id, n_service_id;
    logic [15:0]          r_ts_id, n_ts_id;
    logic [15:0]          r_onid, n_onid;
    logic [7:0]           r_seg_last, n_seg_last;
    logic [7:0]           r_last_table, n_last_table;
    logic [7:0]           r_evt [0:C_EVENT_BYTES-2];
    logic                 w_accept, w_active, w_in_loop, w_evt_we;

    assign o_in_ready = !i_q_status.full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_dll      = {r_evt[10][3:0], i_section_byte};

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_total      = r_total;
        n_skip       = r_skip;
        n_idx        = r_idx;
        n_service_id = r_service_id;
        n_ts_id      = r_ts_id;
        n_onid       = r_onid;
        n_seg_last   = r_seg_last;
        n_last_table = r_last_table;
        o_push       = 1'b0;
        w_evt_we     = 1'b0;
        w_in_loop    = 1'b0;
        w_pos1       = '0;

        w_phase = r_phase;
        w_pos   = r_pos;
        w_total = r_total;
        w_skip  = r_skip;
        w_idx   = r_idx;
        // A first byte restarts the section and drops any partial event
        if (i_first_byte) begin
            w_phase = PH_HEADER;
            w_pos   = '0;
            w_total = '0;
            w_skip  = '0;
            w_idx   = '0;
        end

        w_active = w_accept && (i_first_byte || r_phase != PH_IDLE);

        if (w_active) begin
            n_phase = w_phase;
            n_total = w_total;
            n_skip  = w_skip;
            n_idx   = w_idx;
            if (i_first_byte) begin
                n_service_id = '0;
                n_ts_id      = '0;
                n_onid       = '0;
                n_seg_last   = '0;
                n_last_table = '0;
            end

            case (w_pos)
                P_LEN_HI:   n_total = C_TOTAL_W'(i_section_byte[3:0]);
                P_LEN_LO:   n_total = C_TOTAL_W'({w_total[3:0], i_section_byte})
                                      + C_TOTAL_W'(C_LEN_OFFSET);
                P_SID_HI:   n_service_id[15:8] = i_section_byte;
                P_SID_LO:   n_service_id[7:0]  = i_section_byte;
                P_TSID_HI:  n_ts_id[15:8]      = i_section_byte;
                P_TSID_LO:  n_ts_id[7:0]       = i_section_byte;
                P_ONID_HI:  n_onid[15:8]       = i_section_byte;
                P_ONID_LO:  n_onid[7:0]        = i_section_byte;
                P_SEG_LAST: n_seg_last         = i_section_byte;
                P_LAST_TABLE: begin
                    n_last_table = i_section_byte;
                    n_phase      = PH_EVENT;
                end
                default: ;
            endcase

            // Event loop stops short of the CRC
            w_in_loop = (w_pos >= P_LOOP_START) &&
                        (C_TOTAL_W'(w_pos) + C_TOTAL_W'(C_CRC_BYTES) < w_total);

            if (w_in_loop) begin
                case (w_phase)
                    PH_SKIP: begin
                        if (w_skip != '0) begin
                            n_skip = w_skip - C_DLL_W'(1);
                        end
                        if (w_skip <= C_DLL_W'(1)) begin
                            n_phase = PH_EVENT;
                        end
                    end
                    PH_EVENT: begin
                        if (w_idx == C_IDX_W'(C_EVENT_BYTES - 1)) begin
                            o_push = 1'b1;
                            n_idx  = '0;
                            if (w_dll != '0) begin
                                n_skip  = w_dll;
                                n_phase = PH_SKIP;
                            end
                        end else begin
                            w_evt_we = 1'b1;
                            n_idx    = w_idx + C_IDX_W'(1);
                        end
                    end
                    default: ;
                endcase
            end

            w_pos1 = C_TOTAL_W'(w_pos) + C_TOTAL_W'(1);
            if ((w_pos1 >= C_TOTAL_W'(C_LEN_OFFSET) && w_pos1 >= n_total) ||
                w_pos1 >= C_TOTAL_W'(MaxSectionBytes)) begin
                n_phase = PH_IDLE;
                n_pos   = '0;
            end else begin
                n_pos = w_pos1[C_POS_W-1:0];
            end
        end
    end

    always_comb begin
        o_rec.event_id               = {r_evt[0], r_evt[1]};
        o_rec.start_mjd              = {r_evt[2], r_evt[3]};
        o_rec.start_bcd              = {r_evt[4], r_evt[5], r_evt[6]};
        o_rec.duration_bcd           = {r_evt[7], r_evt[8], r_evt[9]};
        o_rec.running_status         = r_evt[10][7:5];
        o_rec.free_ca_mode           = r_evt[10][4];
        o_rec.descriptor_loop_length = w_dll;
        o_rec.service_id             = r_service_id;
        o_rec.transport_stream_id    = r_ts_id;
        o_rec.original_network_id    = r_onid;
        o_rec.segment_last_section   = r_seg_last;
        o_rec.last_table_number      = r_last_table;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_pos        <= '0;
            r_total      <= '0;
            r_skip       <= '0;
            r_idx        <= '0;
            r_service_id <= '0;
            r_ts_id      <= '0;
            r_onid       <= '0;
            r_seg_last   <= '0;
            r_last_table <= '0;
        end else begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_total      <= n_total;
            r_skip       <= n_skip;
            r_idx        <= n_idx;
            r_service_id <= n_service_id;
            r_ts_id      <= n_ts_id;
            r_onid       <= n_onid;
            r_seg_last   <= n_seg_last;
            r_last_table <= n_last_table;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_evt_we) begin
            r_evt[w_idx] <= i_section_byte;
        end
    end

    `EEP_ASSERT_SAME(a_push_in_event, o_push, r_phase == PH_EVENT, "event pushed outside event phase")
    `EEP_ASSERT_SAME(a_idx_range, 1'b1, r_idx <= C_IDX_W'(C_EVENT_BYTES - 1), "event index overrun")

endmodule

// ===== src/eep_queue.sv =====
// Short record queue between the section walker and the output stage
`include "eit_event_loop_parser_assert.svh"

module eep_queue import eep_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_evt_rec      i_rec,
    input  logic          i_pop,
    output t_evt_rec      o_rec,
    output t_queue_status o_status
);

    t_evt_rec              r_mem [0:C_QUEUE_DEPTH-1];
    logic [C_QPTR_W-1:0]   r_wr, r_rd;
    logic [C_QPTR_W:0]     r_count;

    assign o_rec              = r_mem[r_rd];
    assign o_status.full      = (r_count == (C_QPTR_W+1)'(C_QUEUE_DEPTH));
    assign o_status.not_empty = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + C_QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + C_QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (C_QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (C_QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    `EEP_ASSERT_SAME(a_count_max, 1'b1, r_count <= (C_QPTR_W+1)'(C_QUEUE_DEPTH), "queue overflow")
    `EEP_ASSERT_SAME(a_pop_nonempty, i_pop, r_count != '0, "pop from empty queue")

endmodule

// ===== src/eep_back.sv =====
// Output stage: BCD decode of event times and the result register
`include "eit_event_loop_parser_assert.svh"

module eep_back import eep_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_evt_rec           i_rec,
    input  t_queue_status      i_q_status,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_event_id,
    output logic [15:0]        o_start_mjd,
    output logic [19:0]        o_start_time_value,
    output logic [19:0]        o_duration_value,
    output logic [2:0]         o_running_status,
    output logic               o_free_ca_mode,
    output logic [C_DLL_W-1:0] o_descriptor_loop_length,
    output logic [15:0]        o_service_id,
    output logic [15:0]        o_transport_stream_id,
    output logic [15:0]        o_original_network_id,
    output logic [7:0]         o_segment_last_section,
    output logic [7:0]         o_last_table_number
);

    // Weight six nibbles as decimal hhmmss; clamp a sum above 999999 at that top value
    function automatic logic [19:0] bcd_decode(input logic [23:0] bcd);
        logic [7:0]  hh;
        logic [7:0]  mm;
        logic [7:0]  ss;
        logic [20:0] sum;
        hh  = 8'(bcd[23:20]) * 8'd10 + 8'(bcd[19:16]);
        mm  = 8'(bcd[15:12]) * 8'd10 + 8'(bcd[11:8]);
        ss  = 8'(bcd[7:4])   * 8'd10 + 8'(bcd[3:0]);
        sum = 21'(hh) * 21'd10000 + 21'(mm) * 21'd100 + 21'(ss);
        return (sum > 21'(C_BCD_MAX)) ? 20'(C_BCD_MAX) : sum[19:0];
    endfunction

    logic r_valid;

    assign o_out_valid = r_valid;
    assign o_pop       = i_q_status.not_empty && (!r_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_event_id               <= i_rec.event_id;
            o_start_mjd              <= i_rec.start_mjd;
            o_start_time_value       <= bcd_decode(i_rec.start_bcd);
            o_duration_value         <= bcd_decode(i_rec.duration_bcd);
            o_running_status         <= i_rec.running_status;
            o_free_ca_mode           <= i_rec.free_ca_mode;
            o_descriptor_loop_length <= i_rec.descriptor_loop_length;
            o_service_id             <= i_rec.service_id;
            o_transport_stream_id    <= i_rec.transport_stream_id;
            o_original_network_id    <= i_rec.original_network_id;
            o_segment_last_section   <= i_rec.segment_last_section;
            o_last_table_number      <= i_rec.last_table_number;
        end
    end

    `EEP_ASSERT_NEXT(a_pop_loads, o_pop, r_valid, "popped record not presented")

endmodule

// ===== src/eit_event_loop_parser.sv =====
// Event loop parser: one section byte per cycle in, one event record out per header.
// Path: a record is queued on the byte that completes its event header, then popped into the output register.
// Throughput: one byte per cycle; the input stalls only while the four-entry
// record queue is full, which a stalled output eventually causes.
// Reset: synchronous active low, returns to idle awaiting a first byte; no clearing pass.
module eit_event_loop_parser import eep_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_section_byte,
    input  logic               i_first_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_event_id,
    output logic [15:0]        o_start_mjd,
    output logic [19:0]        o_start_time_value,
    output logic [19:0]        o_duration_value,
    output logic [2:0]         o_running_status,
    output logic               o_free_ca_mode,
    output logic [C_DLL_W-1:0] o_descriptor_loop_length,
    output logic [15:0]        o_service_id,
    output logic [15:0]        o_transport_stream_id,
    output logic [15:0]        o_original_network_id,
    output logic [7:0]         o_segment_last_section,
    output logic [7:0]         o_last_table_number
);

    t_queue_status w_q_status;
    t_evt_rec      w_push_rec;
    t_evt_rec      w_head_rec;
    logic          w_push;
    logic          w_pop;

    eep_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_section_byte (i_section_byte),
        .i_first_byte   (i_first_byte),
        .i_q_status     (w_q_status),
        .o_push         (w_push),
        .o_rec          (w_push_rec)
    );

    eep_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_rec    (w_push_rec),
        .i_pop    (w_pop),
        .o_rec    (w_head_rec),
        .o_status (w_q_status)
    );

    eep_back u_back (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_rec                    (w_head_rec),
        .i_q_status               (w_q_status),
        .o_pop                    (w_pop),
        .o_out_valid              (o_out_valid),
        .i_out_ready              (i_out_ready),
        .o_event_id               (o_event_id),
        .o_start_mjd              (o_start_mjd),
        .o_start_time_value       (o_start_time_value),
        .o_duration_value         (o_duration_value),
        .o_running_status         (o_running_status),
        .o_free_ca_mode           (o_free_ca_mode),
        .o_descriptor_loop_length (o_descriptor_loop_length),
        .o_service_id             (o_service_id),
        .o_transport_stream_id    (o_transport_stream_id),
        .o_original_network_id    (o_original_network_id),
        .o_segment_last_section   (o_segment_last_section),
        .o_last_table_number      (o_last_table_number)
    );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the event information section parser
module testbench import eep_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {ST_IDLE, ST_HEADER, ST_EVENT, ST_SKIP} t_parse_stage;

    typedef struct {
        logic [15:0]        event_id;
        logic [15:0]        start_mjd;
        logic [19:0]        start_time_value;
        logic [19:0]        duration_value;
        logic [2:0]         running_status;
        logic               free_ca_mode;
        logic [C_DLL_W-1:0] descriptor_loop_length;
        logic [15:0]        service_id;
        logic [15:0]        transport_stream_id;
        logic [15:0]        original_network_id;
        logic [7:0]         segment_last_section;
        logic [7:0]         last_table_number;
    } t_epg_event;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [7:0]         i_section_byte = 8'h00;
    logic               i_first_byte = 1'b0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [15:0]        o_event_id;
    logic [15:0]        o_start_mjd;
    logic [19:0]        o_start_time_value;
    logic [19:0]        o_duration_value;
    logic [2:0]         o_running_status;
    logic               o_free_ca_mode;
    logic [C_DLL_W-1:0] o_descriptor_loop_length;
    logic [15:0]        o_service_id;
    logic [15:0]        o_transport_stream_id;
    logic [15:0]        o_original_network_id;
    logic [7:0]         o_segment_last_section;
    logic [7:0]         o_last_table_number;

    eit_event_loop_parser u_top (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_in_valid               (i_in_valid),
        .o_in_ready               (o_in_ready),
        .i_section_byte           (i_section_byte),
        .i_first_byte             (i_first_byte),
        .o_out_valid              (o_out_valid),
        .i_out_ready              (i_out_ready),
        .o_event_id               (o_event_id),
        .o_start_mjd              (o_start_mjd),
        .o_start_time_value       (o_start_time_value),
        .o_duration_value         (o_duration_value),
        .o_running_status         (o_running_status),
        .o_free_ca_mode           (o_free_ca_mode),
        .o_descriptor_loop_length (o_descriptor_loop_length),
        .o_service_id             (o_service_id),
        .o_transport_stream_id    (o_transport_stream_id),
        .o_original_network_id    (o_original_network_id),
        .o_segment_last_section   (o_segment_last_section),
        .o_last_table_number      (o_last_table_number)
    );

    // Parser state mirrored by the predictor
    logic [C_POS_W-1:0]   cur_pos;
    logic [C_TOTAL_W-1:0] sect_total;
    logic [15:0]          hdr_sid, hdr_tsid, hdr_onid;
    logic [7:0]           hdr_seg_last, hdr_last_table;
    logic [7:0]           evt_bytes [C_EVENT_BYTES];
    logic [3:0]           evt_count;
    logic [C_DLL_W-1:0]   desc_left;
    t_parse_stage         stage;

    t_epg_event  pending_events [$];
    t_epg_event  want;
    logic [7:0]  sect_q [$];
    int          mismatches = 0;
    int          sent_bytes = 0;
    bit          calm = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [19:0] bcd_to_decimal(input logic [23:0] digits);
        int acc;
        acc = 0;
        for (int k = 5; k >= 0; k--)
            acc = acc * 10 + int'(digits[k*4 +: 4]);
        return (acc > C_BCD_MAX) ? 20'(C_BCD_MAX) : 20'(acc);
    endfunction

    task automatic clear_parser();
        cur_pos        = '0;
        sect_total     = '0;
        hdr_sid        = '0;
        hdr_tsid       = '0;
        hdr_onid       = '0;
        hdr_seg_last   = '0;
        hdr_last_table = '0;
        for (int k = 0; k < C_EVENT_BYTES; k++)
            evt_bytes[k] = '0;
        evt_count      = '0;
        desc_left      = '0;
        stage          = ST_IDLE;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic first);
        int                 nxt;
        logic [C_DLL_W-1:0] dll;
        t_epg_event         rec;
        if (first) begin
            clear_parser();
            stage = ST_HEADER;
        end else if (stage == ST_IDLE) begin
            return;
        end

        case (cur_pos)
            P_LEN_HI:     sect_total = C_TOTAL_W'(b[3:0]);
            P_LEN_LO:     sect_total = C_TOTAL_W'({sect_total[3:0], b}) + C_TOTAL_W'(C_LEN_OFFSET);
            P_SID_HI:     hdr_sid[15:8] = b;
            P_SID_LO:     hdr_sid[7:0] = b;
            P_TSID_HI:    hdr_tsid[15:8] = b;
            P_TSID_LO:    hdr_tsid[7:0] = b;
            P_ONID_HI:    hdr_onid[15:8] = b;
            P_ONID_LO:    hdr_onid[7:0] = b;
            P_SEG_LAST:   hdr_seg_last = b;
            P_LAST_TABLE: hdr_last_table = b;
            default: ;
        endcase

        if (int'(cur_pos) == int'(P_LOOP_START) - 1)
            stage = ST_EVENT;

        // Event loop stops short of the CRC
        if (cur_pos >= P_LOOP_START && int'(cur_pos) + C_CRC_BYTES < int'(sect_total)) begin
            if (stage == ST_SKIP) begin
                if (desc_left != 0)
                    desc_left--;
                if (desc_left == 0)
                    stage = ST_EVENT;
            end else if (stage == ST_EVENT) begin
                evt_bytes[evt_count] = b;
                evt_count++;
                if (evt_count == C_EVENT_BYTES) begin
                    dll = {evt_bytes[10][3:0], evt_bytes[11]};
                    rec.event_id               = {evt_bytes[0], evt_bytes[1]};
                    rec.start_mjd              = {evt_bytes[2], evt_bytes[3]};
                    rec.start_time_value       = bcd_to_decimal({evt_bytes[4], evt_bytes[5],
                                                                 evt_bytes[6]});
                    rec.duration_value         = bcd_to_decimal({evt_bytes[7], evt_bytes[8],
                                                                 evt_bytes[9]});
                    rec.running_status         = evt_bytes[10][7:5];
                    rec.free_ca_mode           = evt_bytes[10][4];
                    rec.descriptor_loop_length = dll;
                    rec.service_id             = hdr_sid;
                    rec.transport_stream_id    = hdr_tsid;
                    rec.original_network_id    = hdr_onid;
                    rec.segment_last_section   = hdr_seg_last;
                    rec.last_table_number      = hdr_last_table;
                    pending_events.insert(pending_events.size(), rec);
                    evt_count = '0;
                    if (dll != 0) begin
                        desc_left = dll;
                        stage     = ST_SKIP;
                    end
                end
            end
        end

        nxt = int'(cur_pos) + 1;
        if ((nxt >= C_LEN_OFFSET && nxt >= int'(sect_total)) || nxt >= MaxSectionBytes) begin
            stage = ST_IDLE;
            nxt   = 0;
        end
        cur_pos = C_POS_W'(nxt);
    endtask

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic first);
        if (!calm) begin
            while ($urandom_range(0, 2) == 0) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid     <= 1'b1;
        i_section_byte <= b;
        i_first_byte   <= first;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        parse_byte(b, first);
    endtask

    // Hold the sender until every pending event record has come out
    task automatic drain_events();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || calm)
            i_out_ready <= 1'b1;
        else
            i_out_ready <= ($urandom_range(0, 2) != 0);
    end

    task automatic check_field(input string name, input logic [19:0] exp_v,
                               input logic [19:0] got_v);
        if (got_v !== exp_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: event record with none expected, event_id %0h",
                             $time, o_event_id);
            end else begin
                want = pending_events.pop_front();
                check_field("event_id", 20'(want.event_id), 20'(o_event_id));
                check_field("start_mjd", 20'(want.start_mjd), 20'(o_start_mjd));
                check_field("start_time_value", want.start_time_value, o_start_time_value);
                check_field("duration_value", want.duration_value, o_duration_value);
                check_field("running_status", 20'(want.running_status),
                            20'(o_running_status));
                check_field("free_ca_mode", 20'(want.free_ca_mode), 20'(o_free_ca_mode));
                check_field("descriptor_loop_length", 20'(want.descriptor_loop_length),
                            20'(o_descriptor_loop_length));
                check_field("service_id", 20'(want.service_id), 20'(o_service_id));
                check_field("transport_stream_id", 20'(want.transport_stream_id),
                            20'(o_transport_stream_id));
                check_field("original_network_id", 20'(want.original_network_id),
                            20'(o_original_network_id));
                check_field("segment_last_section", 20'(want.segment_last_section),
                            20'(o_segment_last_section));
                check_field("last_table_number", 20'(want.last_table_number),
                            20'(o_last_table_number));
            end
        end
    end

    // ------------------------------------------------------------------
    // Section building
    // ------------------------------------------------------------------
    task automatic append_byte(input logic [7:0] b);
        sect_q.insert(sect_q.size(), b);
    endtask

    task automatic set_length(input int len);
        logic [11:0] len12;
        len12     = 12'(len);
        sect_q[1] = {sect_q[1][7:4], len12[11:8]};
        sect_q[2] = len12[7:0];
    endtask

    task automatic start_section(input logic [15:0] sid, input logic [15:0] tsid,
                                 input logic [15:0] onid, input logic [7:0] seg_last,
                                 input logic [7:0] last_table);
        sect_q.delete();
        append_byte(8'($urandom));     // table id
        append_byte(8'($urandom));     // flags; length nibble set later
        append_byte(8'h00);
        append_byte(sid[15:8]);
        append_byte(sid[7:0]);
        repeat (3) append_byte(8'($urandom));
        append_byte(tsid[15:8]);
        append_byte(tsid[7:0]);
        append_byte(onid[15:8]);
        append_byte(onid[7:0]);
        append_byte(seg_last);
        append_byte(last_table);
    endtask

    task automatic push_event(input logic [15:0] id, input logic [15:0] mjd,
                              input logic [23:0] start_bcd, input logic [23:0] dur_bcd,
                              input logic [3:0] status_ca, input logic [11:0] dll,
                              input int n_desc);
        append_byte(id[15:8]);
        append_byte(id[7:0]);
        append_byte(mjd[15:8]);
        append_byte(mjd[7:0]);
        for (int k = 2; k >= 0; k--)
            append_byte(start_bcd[k*8 +: 8]);
        for (int k = 2; k >= 0; k--)
            append_byte(dur_bcd[k*8 +: 8]);
        append_byte({status_ca, dll[11:8]});
        append_byte(dll[7:0]);
        repeat (n_desc) append_byte(8'($urandom));
    endtask

    task automatic end_section();
        repeat (C_CRC_BYTES) append_byte(8'($urandom));
        set_length(sect_q.size() - C_LEN_OFFSET);
    endtask

    function automatic logic [23:0] rand_bcd();
        logic [23:0] v;
        for (int k = 0; k < 6; k++)
            v[k*4 +: 4] = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                                        : 4'($urandom_range(0, 9));
        return v;
    endfunction

    task automatic build_random_section();
        int          n_events;
        logic [11:0] dll;
        start_section(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
        n_events = $urandom_range(0, 4);
        for (int e = 0; e < n_events; e++) begin
            if ($urandom_range(0, 9) == 0) begin
                // long descriptor loop that the section end cuts short
                push_event(16'($urandom), 16'($urandom), rand_bcd(), rand_bcd(),
                           4'($urandom), 12'($urandom), $urandom_range(0, 8));
                break;
            end
            dll = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 60))
                                              : 12'($urandom_range(0, 6));
            push_event(16'($urandom), 16'($urandom), rand_bcd(), rand_bcd(),
                       4'($urandom), dll, int'(dll));
        end
        end_section();
    endtask

    task automatic send_section(input int n_bytes);
        for (int k = 0; k < n_bytes && k < sect_q.size(); k++)
            send_byte(sect_q[k], k == 0);
        sent_bytes += n_bytes;
    endtask

    task automatic send_noise(input int n_bytes);
        repeat (n_bytes) send_byte(8'($urandom), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_idle_bytes();
        send_noise(3);
        drain_events();
    endtask

    task automatic test_short_sections();
        // length zero, length cutting the header, and a loop with no room
        start_section(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        set_length(0);
        send_section(6);
        start_section(16'hA5A5, 16'h5A5A, 16'h1234, 8'h81, 8'h7E);
        set_length(6);
        send_section(14);
        start_section(16'h1111, 16'h2222, 16'h3333, 8'h44, 8'h55);
        end_section();
        send_section(sect_q.size());
        drain_events();
    endtask

    task automatic test_event_extremes();
        start_section(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        push_event(16'hFFFF, 16'hFFFF, 24'h235959, 24'h999999, 4'hF, 12'h000, 0);
        push_event(16'h0000, 16'h0000, 24'hFFFFFF, 24'hF0F0F0, 4'h0, 12'h000, 0);
        end_section();
        send_section(sect_q.size());
        start_section(16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        push_event(16'h8001, 16'hC000, 24'h000000, 24'h001530, 4'hA, 12'h000, 0);
        push_event(16'h7FFE, 16'h3FFF, 24'h9A0000, 24'h0000AF, 4'h5, 12'h000, 0);
        end_section();
        send_section(sect_q.size());
        drain_events();
    endtask

    task automatic test_skip_and_cut_off();
        // descriptors skipped, then a header cut off at the loop end
        start_section(16'h0102, 16'h0304, 16'h0506, 8'h07, 8'h08);
        push_event(16'h1001, 16'hE000, 24'h120000, 24'h013000, 4'h9, 12'h003, 3);
        push_event(16'h1002, 16'hE001, 24'h133000, 24'h000500, 4'h2, 12'h000, 0);
        repeat (7) append_byte(8'($urandom));
        end_section();
        send_section(sect_q.size());
        // descriptor loop running past the loop end
        start_section(16'hBEEF, 16'hCAFE, 16'hF00D, 8'h10, 8'h4F);
        push_event(16'h2001, 16'hD123, 24'h065959, 24'h020000, 4'hC, 12'hFFF, 5);
        end_section();
        send_section(sect_q.size());
        drain_events();
    endtask

    task automatic test_restart_mid_section();
        start_section(16'h4444, 16'h5555, 16'h6666, 8'h77, 8'h88);
        end_section();
        send_section(6);
        start_section(16'h9999, 16'hAAAA, 16'hBBBB, 8'hCC, 8'hDD);
        push_event(16'h3001, 16'h1111, 24'h101010, 24'h020202, 4'h3, 12'h000, 0);
        push_event(16'h3002, 16'h2222, 24'h111111, 24'h030303, 4'h6, 12'h000, 0);
        end_section();
        send_section(20);
        start_section(16'h0F0F, 16'hF0F0, 16'h00FF, 8'h3C, 8'hC3);
        push_event(16'h3003, 16'h3333, 24'h121212, 24'h040404, 4'h1, 12'h002, 2);
        end_section();
        send_section(sect_q.size());
        drain_events();
    endtask

    task automatic test_random_sections();
        int n;
        int kind;
        int first_count;
        int section_no;
        first_count = sent_bytes;
        section_no  = 0;
        while (sent_bytes - first_count < 950) begin
            calm = (section_no >= 10 && section_no < 18);
            build_random_section();
            n    = sect_q.size();
            kind = $urandom_range(0, 11);
            if (kind == 0) begin
                set_length($urandom_range(0, 80));
            end else if (kind == 1) begin
                n = $urandom_range(1, n);
            end else if (kind == 2) begin
                for (int k = 1; k < n; k++)
                    sect_q[k] = 8'($urandom);
            end
            send_section(n);
            if ($urandom_range(0, 3) == 0)
                send_noise($urandom_range(1, 6));
            if (section_no % 9 == 8)
                drain_events();
            section_no++;
        end
        calm = 1'b0;
        drain_events();
    endtask

    initial begin
        clear_parser();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_bytes();
        test_short_sections();
        test_event_extremes();
        test_skip_and_cut_off();
        test_restart_mid_section();
        test_random_sections();
        drain_events();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
